// ===== rtl/lses_pkg.sv =====
`timescale 1ns / 1ps

package lses_pkg;

    // most writes that one item can cause
    localparam int RES_MAX = 16;

    // width of the shared adder
    localparam int ALU_W = 24;

    localparam logic [7:0] CIRCLE_ADD = 8'd2;

    // register indexes on the configuration channel
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EFFECT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HUE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LED_FIRST  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT  = 3'd7;

    // effect codes
    localparam logic [3:0] EFF_STATIC   = 4'd0;
    localparam logic [3:0] EFF_BLINK    = 4'd1;
    localparam logic [3:0] EFF_GRADIENT = 4'd2;
    localparam logic [3:0] EFF_RAINBOW  = 4'd3;
    localparam logic [3:0] EFF_RANDOM   = 4'd4;
    localparam logic [3:0] EFF_BREATH   = 4'd5;
    localparam logic [3:0] EFF_WIPE     = 4'd6;
    localparam logic [3:0] EFF_SCAN     = 4'd7;
    localparam logic [3:0] EFF_CIRCLE   = 4'd8;

    typedef struct packed {
        logic       enable;
        logic [3:0] effect;
        logic [7:0] speed;
        logic [7:0] base_hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
        logic [7:0] led_first;
        logic [4:0] led_count;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        enable:     1'b1,
        effect:     EFF_STATIC,
        speed:      8'd1,
        base_hue:   8'd0,
        saturation: 8'd255,
        brightness: 8'd255,
        led_first:  8'd0,
        led_count:  5'd16
    };

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] y;
        logic             cout;
    } alu_rsp_t;

    typedef struct packed {
        logic [7:0] led_index;
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
        logic       last;
    } led_wr_t;

    // breathing brightness curve
    localparam logic [7:0] BREATH_CURVE [256] = '{
        8'h22, 8'h23, 8'h25, 8'h26, 8'h28, 8'h29, 8'h2A, 8'h2C,
        8'h2D, 8'h2F, 8'h30, 8'h32, 8'h33, 8'h35, 8'h36, 8'h38,
        8'h3A, 8'h3B, 8'h3D, 8'h3E, 8'h40, 8'h42, 8'h43, 8'h45,
        8'h47, 8'h49, 8'h4A, 8'h4C, 8'h4E, 8'h50, 8'h51, 8'h53,
        8'h55, 8'h57, 8'h59, 8'h5A, 8'h5C, 8'h5E, 8'h60, 8'h62,
        8'h64, 8'h66, 8'h68, 8'h69, 8'h6B, 8'h6D, 8'h6F, 8'h71,
        8'h73, 8'h75, 8'h77, 8'h79, 8'h7B, 8'h7D, 8'h7F, 8'h81,
        8'h83, 8'h85, 8'h87, 8'h89, 8'h8A, 8'h8C, 8'h8E, 8'h90,
        8'h92, 8'h94, 8'h96, 8'h98, 8'h9A, 8'h9C, 8'h9E, 8'h9F,
        8'hA1, 8'hA3, 8'hA5, 8'hA7, 8'hA8, 8'hAA, 8'hAC, 8'hAE,
        8'hAF, 8'hB1, 8'hB3, 8'hB4, 8'hB6, 8'hB8, 8'hB9, 8'hBB,
        8'hBC, 8'hBE, 8'hBF, 8'hC1, 8'hC2, 8'hC3, 8'hC5, 8'hC6,
        8'hC7, 8'hC9, 8'hCA, 8'hCB, 8'hCC, 8'hCD, 8'hCE, 8'hD0,
        8'hD1, 8'hD2, 8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hD6, 8'hD7,
        8'hD7, 8'hD8, 8'hD9, 8'hD9, 8'hDA, 8'hDA, 8'hDB, 8'hDB,
        8'hDB, 8'hDC, 8'hDC, 8'hDC, 8'hDC, 8'hDC, 8'hDD, 8'hDD,
        8'hDD, 8'hDD, 8'hDC, 8'hDC, 8'hDC, 8'hDC, 8'hDC, 8'hDB,
        8'hDB, 8'hDB, 8'hDA, 8'hDA, 8'hD9, 8'hD9, 8'hD8, 8'hD7,
        8'hD7, 8'hD6, 8'hD5, 8'hD4, 8'hD3, 8'hD2, 8'hD2, 8'hD1,
        8'hD0, 8'hCE, 8'hCD, 8'hCC, 8'hCB, 8'hCA, 8'hC9, 8'hC7,
        8'hC6, 8'hC5, 8'hC3, 8'hC2, 8'hC1, 8'hBF, 8'hBE, 8'hBC,
        8'hBB, 8'hB9, 8'hB8, 8'hB6, 8'hB4, 8'hB3, 8'hB1, 8'hAF,
        8'hAE, 8'hAC, 8'hAA, 8'hA8, 8'hA7, 8'hA5, 8'hA3, 8'hA1,
        8'h9F, 8'h9E, 8'h9C, 8'h9A, 8'h98, 8'h96, 8'h94, 8'h92,
        8'h90, 8'h8E, 8'h8C, 8'h8A, 8'h89, 8'h87, 8'h85, 8'h83,
        8'h81, 8'h7F, 8'h7D, 8'h7B, 8'h79, 8'h77, 8'h75, 8'h73,
        8'h71, 8'h6F, 8'h6D, 8'h6B, 8'h69, 8'h68, 8'h66, 8'h64,
        8'h62, 8'h60, 8'h5E, 8'h5C, 8'h5A, 8'h59, 8'h57, 8'h55,
        8'h53, 8'h51, 8'h50, 8'h4E, 8'h4C, 8'h4A, 8'h49, 8'h47,
        8'h45, 8'h43, 8'h42, 8'h40, 8'h3E, 8'h3D, 8'h3B, 8'h3A,
        8'h38, 8'h36, 8'h35, 8'h33, 8'h32, 8'h30, 8'h2F, 8'h2D,
        8'h2C, 8'h2A, 8'h29, 8'h28, 8'h26, 8'h25, 8'h23, 8'h22
    };

endpackage

// ===== rtl/lses_in_if.sv =====
`timescale 1ns / 1ps

// command items: timer tick or restart
interface lses_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] ticks;
    logic [7:0]  random_hue;

    modport source (output valid, mode, ticks, random_hue, input ready);
    modport sink (input valid, mode, ticks, random_hue, output ready);
endinterface

// ===== rtl/lses_out_if.sv =====
`timescale 1ns / 1ps

// per-led colour write items
interface lses_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] led_index;
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
    logic       last;

    modport source (output valid, led_index, hue, sat, val, last, input ready);
    modport sink (input valid, led_index, hue, sat, val, last, output ready);
endinterface

// ===== rtl/lses_cfg_if.sv =====
`timescale 1ns / 1ps

// register write channel
interface lses_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/lses_alu.sv =====
`timescale 1ns / 1ps

// shared add / subtract unit; cout high on subtract means a >= b
module lses_alu
    import lses_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ALU_W:0] sum;
    logic [ALU_W-1:0] b_op;

    assign b_op = req.sub ? ~req.b : req.b;
    assign sum  = {1'b0, req.a} + {1'b0, b_op} + {{ALU_W{1'b0}}, req.sub};

    assign rsp.y    = sum[ALU_W-1:0];
    assign rsp.cout = sum[ALU_W];

endmodule

// ===== rtl/lses_cfg_regs.sv =====
`timescale 1ns / 1ps

// configuration register file
module lses_cfg_regs
    import lses_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lses_cfg_if.sink   cfg,
    output cfg_t       csr
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign csr       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_ENABLE:     cfg_next.enable     = cfg.data[0];
                REG_EFFECT:     cfg_next.effect     = cfg.data[3:0];
                REG_SPEED:      cfg_next.speed      = cfg.data;
                REG_BASE_HUE:   cfg_next.base_hue   = cfg.data;
                REG_SATURATION: cfg_next.saturation = cfg.data;
                REG_BRIGHTNESS: cfg_next.brightness = cfg.data;
                REG_LED_FIRST:  cfg_next.led_first  = cfg.data;
                REG_LED_COUNT:  cfg_next.led_count  = cfg.data[4:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/lses_out_stage.sv =====
`timescale 1ns / 1ps

// output register between the sequencer and the write channel
module lses_out_stage
    import lses_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  led_wr_t     wr,
    output logic        free,
    lses_out_if.source  led
);

    logic    valid_reg;
    led_wr_t data_reg;

    assign free = !valid_reg || led.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            data_reg <= wr;
        end
    end

    assign led.valid     = valid_reg;
    assign led.led_index = data_reg.led_index;
    assign led.hue       = data_reg.hue;
    assign led.sat       = data_reg.sat;
    assign led.val       = data_reg.val;
    assign led.last      = data_reg.last;

endmodule

// ===== rtl/led_strip_effect_sequencer.sv =====
`timescale 1ns / 1ps

// LED strip effect sequencer: takes tick and restart items on cmd and sends HSV
// writes, one per LED, on led, the final write of an item flagged by last. Items
// run one at a time through a single shared 24-bit adder: an accepted item is
// taken in S_IDLE, then a tick with the block enabled and a timed effect forms
// the shift-add product elapsed * speed in S_MUL and compares it with the step
// delay, gradient and rainbow run the restoring divide for the hue spacing in
// S_DIV, S_STEP plans the step, and the writes leave from S_EMIT at one per
// cycle while led is ready. A restart of wipe or scan and a disabled tick write
// every LED off; a tick of a timed effect that falls short of the step delay,
// and any other item with no writes, go back to idle. The last write sits in an
// output register so the next item is taken while it waits. There is no clearing
// pass after reset. Configuration must be written only while no item is in
// flight; the block itself does not enforce this.

module led_strip_effect_sequencer
    import lses_pkg::*;
#(
    parameter int LED_COUNT  = 16,
    parameter int HUE_FULL   = 255,
    parameter int STEP_DELAY = 15000
)
(
    input  logic       clk,
    input  logic       rst_n,
    lses_in_if.sink    cmd,
    lses_out_if.source led,
    lses_cfg_if.sink   cfg
);

    // leds actually driven never exceed the result limit
    localparam int         MAX_N     = (LED_COUNT < RES_MAX) ? LED_COUNT : RES_MAX;
    localparam logic [4:0] MAX_N_W   = 5'(MAX_N);
    localparam logic [7:0] HUE_DVD   = 8'(HUE_FULL);
    localparam logic [ALU_W-1:0] DELAY_W = ALU_W'(STEP_DELAY);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_STEP = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    cfg_t     csr;
    alu_req_t alu_req;
    alu_rsp_t alu_rsp;
    led_wr_t  wr;
    logic     out_free;
    logic     out_load;

    // control state
    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [7:0] running_hue_reg, running_hue_next;
    logic [5:0] position_reg, position_next;
    logic       wipe_lit_reg, wipe_lit_next;
    logic [7:0] breath_index_reg, breath_index_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [4:0] em_left_reg, em_left_next;

    // datapath registers
    logic [ALU_W-1:0] acc_reg, acc_next;
    logic [ALU_W-1:0] mcand_reg, mcand_next;
    logic [7:0] mplier_reg, mplier_next;
    logic [4:0] rem_reg, rem_next;
    logic [7:0] dvd_reg, dvd_next;
    logic [7:0] q_reg, q_next;
    logic [7:0] rnd_reg, rnd_next;
    logic [3:0] em_pos_reg, em_pos_next;
    logic [3:0] em_pos2_reg, em_pos2_next;
    logic [7:0] em_hue_reg, em_hue_next;
    logic [7:0] em_step_reg, em_step_next;
    logic [7:0] em_sat_reg, em_sat_next;
    logic [7:0] em_val_reg, em_val_next;
    logic       em_off_reg, em_off_next;
    logic       em_scan_reg, em_scan_next;

    // derived values
    logic [4:0]  n_used;
    logic [16:0] el_sum;
    logic [15:0] el_sat;
    logic [3:0]  pos_cl;
    logic [4:0]  pos_inc;
    logic        pos_wrap;
    logic [3:0]  pos_prev;

    lses_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .csr   (csr)
    );

    lses_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    lses_out_stage u_out_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (out_load),
        .wr    (wr),
        .free  (out_free),
        .led   (led)
    );

    assign cmd.ready = (state_reg == S_IDLE);

    // led count clamped to 1 .. MAX_N
    assign n_used = (csr.led_count == 5'd0) ? 5'd1 :
                    (csr.led_count > MAX_N_W) ? MAX_N_W : csr.led_count;

    // saturating elapsed accumulation
    assign el_sum = {1'b0, elapsed_reg} + {1'b0, cmd.ticks};
    assign el_sat = el_sum[16] ? 16'hFFFF : el_sum[15:0];

    // wipe / scan position, off the strip reads as zero
    assign pos_cl   = (position_reg >= 6'(n_used)) ? 4'd0 : position_reg[3:0];
    assign pos_inc  = {1'b0, pos_cl} + 5'd1;
    assign pos_wrap = (pos_inc == n_used);
    assign pos_prev = (pos_cl == 4'd0) ? 4'(n_used - 5'd1) : (pos_cl - 4'd1);

    // operand select for the shared adder
    always_comb
    begin
        alu_req = '0;
        case (state_reg)
            S_MUL:
            begin
                alu_req.a = acc_reg;
                if (cnt_reg[3])
                begin
                    // product vs step delay
                    alu_req.b   = DELAY_W;
                    alu_req.sub = 1'b1;
                end
                else
                begin
                    alu_req.b = mcand_reg;
                end
            end
            S_DIV:
            begin
                alu_req.a   = {{(ALU_W-6){1'b0}}, rem_reg, dvd_reg[7]};
                alu_req.b   = {{(ALU_W-5){1'b0}}, n_used};
                alu_req.sub = 1'b1;
            end
            S_EMIT:
            begin
                // hue of the next gradient led
                alu_req.a = {{(ALU_W-8){1'b0}}, em_hue_reg};
                alu_req.b = {{(ALU_W-8){1'b0}}, em_step_reg};
            end
            default:
            begin
                alu_req = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        running_hue_next  = running_hue_reg;
        position_next     = position_reg;
        wipe_lit_next     = wipe_lit_reg;
        breath_index_next = breath_index_reg;
        elapsed_next      = elapsed_reg;
        em_left_next      = em_left_reg;
        acc_next          = acc_reg;
        mcand_next        = mcand_reg;
        mplier_next       = mplier_reg;
        rem_next          = rem_reg;
        dvd_next          = dvd_reg;
        q_next            = q_reg;
        rnd_next          = rnd_reg;
        em_pos_next       = em_pos_reg;
        em_pos2_next      = em_pos2_reg;
        em_hue_next       = em_hue_reg;
        em_step_next      = em_step_reg;
        em_sat_next       = em_sat_reg;
        em_val_next       = em_val_reg;
        em_off_next       = em_off_reg;
        em_scan_next      = em_scan_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    elapsed_next = el_sat;
                    rnd_next     = cmd.random_hue;
                    acc_next     = '0;
                    mcand_next   = {{(ALU_W-16){1'b0}}, el_sat};
                    mplier_next  = csr.speed;
                    rem_next     = '0;
                    dvd_next     = HUE_DVD;
                    cnt_next     = '0;
                    // default plan: every led off
                    em_pos_next  = '0;
                    em_left_next = n_used;
                    em_step_next = '0;
                    em_off_next  = 1'b1;
                    em_scan_next = 1'b0;
                    em_hue_next  = running_hue_reg;
                    em_sat_next  = csr.saturation;
                    em_val_next  = csr.brightness;

                    if (cmd.mode)
                    begin
                        // restart, acts even when disabled
                        running_hue_next = csr.base_hue;
                        if (csr.effect == EFF_WIPE)
                        begin
                            wipe_lit_next = 1'b1;
                            position_next = '0;
                            state_next    = S_EMIT;
                        end
                        else if (csr.effect == EFF_SCAN)
                        begin
                            position_next = '0;
                            state_next    = S_EMIT;
                        end
                    end
                    else if (!csr.enable)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (csr.effect == EFF_STATIC)
                    begin
                        state_next = S_STEP;
                    end
                    else if (csr.effect == EFF_GRADIENT)
                    begin
                        state_next = S_DIV;
                    end
                    else if (csr.effect <= EFF_CIRCLE)
                    begin
                        state_next = S_MUL;
                    end
                end
            end

            S_MUL:
            begin
                if (!cnt_reg[3])
                begin
                    // one multiplier bit per cycle
                    if (mplier_reg[0])
                    begin
                        acc_next = alu_rsp.y;
                    end
                    mcand_next  = {mcand_reg[ALU_W-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[7:1]};
                    cnt_next    = cnt_reg + 4'd1;
                end
                else
                begin
                    cnt_next = '0;
                    if (alu_rsp.cout)
                    begin
                        state_next = (csr.effect == EFF_RAINBOW) ? S_DIV : S_STEP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                if (alu_rsp.cout)
                begin
                    rem_next = alu_rsp.y[4:0];
                end
                else
                begin
                    rem_next = {rem_reg[3:0], dvd_reg[7]};
                end
                q_next   = {q_reg[6:0], alu_rsp.cout};
                dvd_next = {dvd_reg[6:0], 1'b0};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg[2:0] == 3'd7)
                begin
                    cnt_next   = '0;
                    state_next = S_STEP;
                end
            end

            S_STEP:
            begin
                elapsed_next = '0;
                state_next   = S_EMIT;
                em_off_next  = 1'b0;
                case (csr.effect)
                    EFF_STATIC:
                    begin
                        em_off_next = 1'b0;
                    end
                    EFF_BLINK:
                    begin
                        em_off_next   = !position_reg[0];
                        position_next = position_reg + 6'd1;
                    end
                    EFF_GRADIENT:
                    begin
                        em_step_next = q_reg;
                    end
                    EFF_RAINBOW:
                    begin
                        em_step_next     = q_reg;
                        running_hue_next = running_hue_reg + 8'd1;
                    end
                    EFF_RANDOM:
                    begin
                        em_hue_next = rnd_reg;
                    end
                    EFF_BREATH:
                    begin
                        em_val_next       = BREATH_CURVE[breath_index_reg];
                        breath_index_next = breath_index_reg + 8'd1;
                    end
                    EFF_WIPE:
                    begin
                        em_left_next = 5'd1;
                        em_pos_next  = pos_cl;
                        em_off_next  = !wipe_lit_reg;
                        if (pos_wrap)
                        begin
                            position_next    = '0;
                            wipe_lit_next    = !wipe_lit_reg;
                            running_hue_next = running_hue_reg + 8'd1;
                        end
                        else
                        begin
                            position_next = 6'(pos_inc);
                        end
                    end
                    EFF_SCAN:
                    begin
                        // previous led off, then current led lit
                        em_left_next = 5'd2;
                        em_pos_next  = pos_prev;
                        em_pos2_next = pos_cl;
                        em_off_next  = 1'b1;
                        em_scan_next = 1'b1;
                        if (pos_wrap)
                        begin
                            position_next    = '0;
                            running_hue_next = running_hue_reg + 8'd1;
                        end
                        else
                        begin
                            position_next = 6'(pos_inc);
                        end
                    end
                    EFF_CIRCLE:
                    begin
                        running_hue_next = running_hue_reg + CIRCLE_ADD;
                    end
                    default:
                    begin
                        em_off_next = 1'b0;
                    end
                endcase
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    em_left_next = em_left_reg - 5'd1;
                    if (em_scan_reg)
                    begin
                        em_pos_next  = em_pos2_reg;
                        em_off_next  = 1'b0;
                        em_scan_next = 1'b0;
                    end
                    else
                    begin
                        em_pos_next = em_pos_reg + 4'd1;
                        em_hue_next = alu_rsp.y[7:0];
                    end
                    if (em_left_reg == 5'd1)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // write going into the output register
    assign out_load     = (state_reg == S_EMIT);
    assign wr.led_index = {4'd0, em_pos_reg} + csr.led_first;
    assign wr.hue       = em_off_reg ? 8'd0 : em_hue_reg;
    assign wr.sat       = em_off_reg ? 8'd0 : em_sat_reg;
    assign wr.val       = em_off_reg ? 8'd0 : em_val_reg;
    assign wr.last      = (em_left_reg == 5'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            running_hue_reg  <= '0;
            position_reg     <= '0;
            wipe_lit_reg     <= 1'b1;
            breath_index_reg <= '0;
            elapsed_reg      <= '0;
            em_left_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            running_hue_reg  <= running_hue_next;
            position_reg     <= position_next;
            wipe_lit_reg     <= wipe_lit_next;
            breath_index_reg <= breath_index_next;
            elapsed_reg      <= elapsed_next;
            em_left_reg      <= em_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        q_reg       <= q_next;
        rnd_reg     <= rnd_next;
        em_pos_reg  <= em_pos_next;
        em_pos2_reg <= em_pos2_next;
        em_hue_reg  <= em_hue_next;
        em_step_reg <= em_step_next;
        em_sat_reg  <= em_sat_next;
        em_val_reg  <= em_val_next;
        em_off_reg  <= em_off_next;
        em_scan_reg <= em_scan_next;
    end

endmodule

// ===== rtl/lses_checker.sv =====
`timescale 1ns / 1ps

// port-level checks on the sequencer
module lses_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_ready,
    input logic       led_valid,
    input logic       led_ready,
    input logic [7:0] led_index,
    input logic [7:0] led_hue,
    input logic [7:0] led_sat,
    input logic [7:0] led_val,
    input logic       led_last
);

    // a rising write is always preceded by a sample in which no item could be taken
    a_write_from_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(led_valid) |-> $past(!cmd_ready)
    ) else $error("write appeared while idle");

    // writes of an item still pending: no new item may be taken
    a_busy_until_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (led_valid && !led_last) |-> !cmd_ready
    ) else $error("item taken before its last write");

    // stalled write holds
    a_write_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (led_valid && !led_ready) |=> (led_valid && $stable(led_index) && $stable(led_hue)
            && $stable(led_sat) && $stable(led_val) && $stable(led_last))
    ) else $error("stalled write changed");

endmodule

bind led_strip_effect_sequencer lses_checker u_lses_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_ready (cmd.ready),
    .led_valid (led.valid),
    .led_ready (led.ready),
    .led_index (led.led_index),
    .led_hue   (led.hue),
    .led_sat   (led.sat),
    .led_val   (led.val),
    .led_last  (led.last)
);
